// ===== hdl/isort_pkg.sv =====
// Shared types and constants for the insertion sorter cell chain.
package isort_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	// Broadcast control that every cell of the chain sees in the same cycle.
	typedef struct packed {
		logic  ins;    // insert the broadcast value this cycle
		logic  pop;    // shift the whole chain one place toward the head
		data_t value;  // value being inserted
	} cell_ctrl_t;

endpackage

// ===== hdl/isort_cell.sv =====
// One cell of the insertion sorter chain: a stored value, its valid bit and the compare.
module isort_cell
	import isort_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       prev_take,
	input  logic       prev_valid,
	input  data_t      prev_val,
	input  logic       next_valid,
	input  data_t      next_val,
	output logic       take,
	output logic       valid,
	output data_t      val
);

	logic  valid_q;
	data_t val_q;

	// A cell takes part in the insertion when it is empty or holds a strictly
	// greater value, so equal values keep their arrival order.
	assign take  = !valid_q || (ctrl.value < val_q);
	assign valid = valid_q;
	assign val   = val_q;

	// Only the first empty cell, the one right behind the occupied run, becomes
	// occupied on an insertion; empty cells further down stay empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end else if (ctrl.ins && take && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			val_q <= next_val;
		end else if (ctrl.ins && take) begin
			val_q <= prev_take ? prev_val : ctrl.value;
		end
	end

endmodule

// ===== hdl/insertion_sorter.sv =====
// Top level of the streaming insertion sorter built from a chain of compare cells.
// Latency: a value is placed in the chain in the cycle it is accepted; after the
// transaction marked last, the smallest value is offered in the next cycle.
// Throughput: one input transaction per cycle while a set fills, then one result
// per cycle while it drains and out_ready is high, as the chain shifts to its head.
// Reset (arst_n low) empties every cell, clears the overflow flag and ends draining.
module insertion_sorter
	import isort_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  data_t value,
	input  logic  last_in,
	output logic  out_valid,
	input  logic  out_ready,
	output data_t sorted_value,
	output logic  last_out,
	output logic  overflow
);

	// Two phases: the chain fills from input transactions, then drains from its head.
	localparam logic ST_FILL  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic             state_q;
	logic             dropped_q;
	cell_ctrl_t       ctrl;
	logic [DEPTH-1:0] take_w;
	logic [DEPTH-1:0] valid_w;
	data_t            val_w [DEPTH];
	logic             in_fire;
	logic             out_fire;
	logic             full;

	// The chain is full when its tail cell holds a value; valid cells always
	// form a contiguous run starting at the head.
	assign full     = valid_w[DEPTH-1];
	assign in_ready = (state_q == ST_FILL);
	assign in_fire  = in_valid && in_ready;

	// Cell zero is the output register: the head of the chain holds the next
	// smallest value, and the result is the last one when cell one is empty.
	assign out_valid    = (state_q == ST_DRAIN) && valid_w[0];
	assign sorted_value = val_w[0];
	assign last_out     = !valid_w[1];
	assign overflow     = dropped_q;
	assign out_fire     = out_valid && out_ready;

	// A value that arrives when every cell is occupied is dropped, not inserted.
	assign ctrl.ins   = in_fire && !full;
	assign ctrl.pop   = out_fire;
	assign ctrl.value = value;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic  prev_take;
			logic  prev_valid;
			data_t prev_val;
			logic  next_valid;
			data_t next_val;

			// The head cell behaves as if an occupied cell stood in front of it.
			if (gi == 0) begin : g_head
				assign prev_take  = 1'b0;
				assign prev_valid = 1'b1;
				assign prev_val   = '0;
			end else begin : g_body
				assign prev_take  = take_w[gi-1];
				assign prev_valid = valid_w[gi-1];
				assign prev_val   = val_w[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign next_valid = 1'b0;
				assign next_val   = '0;
			end else begin : g_link
				assign next_valid = valid_w[gi+1];
				assign next_val   = val_w[gi+1];
			end

			isort_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.prev_take  (prev_take),
				.prev_valid (prev_valid),
				.prev_val   (prev_val),
				.next_valid (next_valid),
				.next_val   (next_val),
				.take       (take_w[gi]),
				.valid      (valid_w[gi]),
				.val        (val_w[gi])
			);
		end
	endgenerate

	// Phase control and the per-set overflow flag. The closing transaction is
	// always stored or dropped against a full chain, so draining never starts
	// on an empty chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (in_fire) begin
						if (full) begin
							dropped_q <= 1'b1;
						end
						if (last_in) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (out_fire && last_out) begin
						state_q   <= ST_FILL;
						dropped_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	// Occupied cells always form a contiguous run from the head of the chain.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_w + 1'b1) & valid_w) == '0)
		else $error("occupied cells are not contiguous from the head");

	// Closing a set always produces a result in the following cycle.
	a_close_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_in) |=> out_valid)
		else $error("closed set produced no result");

	// Results leave in ascending order within a set.
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !last_out) |=> (out_valid && (sorted_value >= $past(sorted_value))))
		else $error("results are not in ascending order");

	// The overflow flag does not change while a set is being drained.
	a_overflow_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DRAIN) && !(out_fire && last_out)) |=> $stable(overflow))
		else $error("overflow changed during a drain");

endmodule
